[rtl/path_dot_segment_canonicalizer_assert.svh]
// Assertion macros shared by the canonicalizer modules.
// Expects signals clk and rst_n in the module that uses them.
`ifndef PATH_DOT_SEGMENT_CANONICALIZER_ASSERT_SVH
`define PATH_DOT_SEGMENT_CANONICALIZER_ASSERT_SVH

// same-cycle implication
`define PDSC_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pdsc assertion failed");

// next-cycle implication
`define PDSC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pdsc assertion failed");

`endif

[rtl/pdsc_pkg.sv]
// Package for the path dot-segment canonicalizer: sizes, codes, result and
// stack command types. No dependencies.
package pdsc_pkg;

  localparam int MAX_LEN   = 1024;
  localparam int MAX_DEPTH = 64;
  localparam int CHAR_BITS = 16;

  localparam int POS_W = $clog2(MAX_LEN);
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int CNT_W = $clog2(MAX_DEPTH + 1);

  localparam logic [CHAR_BITS-1:0] SEP_CH = CHAR_BITS'('h2F);
  localparam logic [CHAR_BITS-1:0] DOT_CH = CHAR_BITS'('h2E);

  typedef enum logic [1:0] {CLS_SEP, CLS_DOT, CLS_DOTDOT, CLS_SEG} class_t;
  typedef enum logic [1:0] {PH_AWAIT, PH_PATH, PH_DRAIN} phase_t;
  typedef enum logic [2:0] {
    ST_OK, ST_EMPTY, ST_NOT_ABS, ST_TOO_LONG, ST_TOO_DEEP
  } status_t;

  typedef struct packed {
    logic                 write_valid;
    logic [POS_W-1:0]     write_pos;
    logic [CHAR_BITS-1:0] write_char;
    logic [LEN_W-1:0]     path_length;
    logic                 done_res;
    status_t              status;
    logic [LEN_W-1:0]     file_start;
    logic [LEN_W-1:0]     file_length;
  } res_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [LEN_W-1:0] push_val;
  } stk_cmd_t;

endpackage

[rtl/pdsc_if.sv]
// Channel interfaces of the canonicalizer: input, result and configuration.
// Depends on pdsc_pkg.
interface pdsc_in_if;
  import pdsc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] char_in;
  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface pdsc_out_if;
  import pdsc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 write_valid;
  logic [POS_W-1:0]     write_pos;
  logic [CHAR_BITS-1:0] write_char;
  logic [LEN_W-1:0]     path_length;
  logic                 done_res;
  logic [2:0]           status;
  logic [LEN_W-1:0]     file_start;
  logic [LEN_W-1:0]     file_length;
  modport source (output valid, output write_valid, output write_pos, output write_char,
                  output path_length, output done_res, output status,
                  output file_start, output file_length, input ready);
  modport sink   (input valid, input write_valid, input write_pos, input write_char,
                  input path_length, input done_res, input status,
                  input file_start, input file_length, output ready);
endinterface

interface pdsc_cfg_if;
  logic valid;
  logic ready;
  logic split_file;
  modport source (output valid, output split_file, input ready);
  modport sink   (input valid, input split_file, output ready);
endinterface

[rtl/pdsc_cell.sv]
// One entry of the segment-start stack; shifts toward the top on pop and
// away from it on push. Depends on pdsc_pkg.
module pdsc_cell (
  input  logic                     clk,
  input  pdsc_pkg::stk_cmd_t       cmd,
  input  logic [pdsc_pkg::LEN_W-1:0] up_val,
  input  logic [pdsc_pkg::LEN_W-1:0] down_val,
  output logic [pdsc_pkg::LEN_W-1:0] q
);
  import pdsc_pkg::*;

  logic [LEN_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      val_r <= up_val;
    end else if (cmd.pop) begin
      val_r <= down_val;
    end
  end

  assign q = val_r;

endmodule

[rtl/pdsc_outbuf.sv]
// Result register with a skid stage: while a result waits, the input side
// can hand over one more. Depends on pdsc_pkg and the assertion header.
module pdsc_outbuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pdsc_pkg::res_t  in_res,
  output logic            out_valid,
  input  logic            out_ready,
  output pdsc_pkg::res_t  out_res
);
  import pdsc_pkg::*;
  `include "path_dot_segment_canonicalizer_assert.svh"

  logic   out_v_r, out_v_nxt;
  logic   skid_v_r, skid_v_nxt;
  res_t   out_d_r, skid_d_r;
  logic   in_fire, out_free;

  assign in_ready = !skid_v_r;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_v_r || out_ready;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (out_free) begin
      out_v_nxt  = skid_v_r || in_fire;
      skid_v_nxt = 1'b0;
    end else if (in_fire) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_d_r <= skid_v_r ? skid_d_r : in_res;
    end else if (in_fire) begin
      skid_d_r <= in_res;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_d_r;

  `PDSC_ASSERT_NOW(a_skid_behind_out, skid_v_r, out_v_r)
  `PDSC_ASSERT_NEXT(a_skid_holds, skid_v_r && !out_ready, skid_v_r && out_v_r)

endmodule

[rtl/path_dot_segment_canonicalizer.sv]
// Top level of the streaming dot-segment canonicalizer for absolute paths.
// Depends on pdsc_pkg, pdsc_if, pdsc_cell, pdsc_outbuf, assertion header.
//
// Usage:
//   in_if carries one path character per transaction; a zero character ends
//   the path. out_if returns exactly one result per character: a write
//   request (write_valid, write_pos, write_char) for the downstream path
//   buffer and the current path_length. The result for the zero carries
//   done_res, status and, with split_file set, file_start/file_length.
//   cfg_if writes split_file; it is always ready and is sampled when the
//   terminator is processed, so write it only between paths.
//   Throughput: one character per cycle while out_if.ready stays high, set by
//   the single decode-and-update of the state registers and the row of stack
//   cells, each of which shifts one segment start per push or pop.
//   Stall: a result register plus one skid entry; with a result waiting and
//   out_if.ready low, it takes one more character, then holds in_if.ready low.
//   Reset (rst_n low, synchronous): control returns to awaiting a new path,
//   split_file clears, buffered results are dropped. No clearing pass.
module path_dot_segment_canonicalizer (
  input  logic        clk,
  input  logic        rst_n,
  pdsc_in_if.sink     in_if,
  pdsc_out_if.source  out_if,
  pdsc_cfg_if.sink    cfg_if
);
  import pdsc_pkg::*;
  `include "path_dot_segment_canonicalizer_assert.svh"

  phase_t           phase_r, phase_nxt;
  class_t           cls_r, cls_nxt;
  status_t          err_r, err_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             split_r;

  logic             in_ready, in_fire;
  logic             is_zero, is_sep, is_dot, too_long, too_deep, can_pop;
  logic [LEN_W-1:0] top_q, pop_top, idx_inc;
  logic [CHAR_BITS-1:0] ch;
  res_t             res_d, res_q;
  logic             res_v;
  stk_cmd_t         cmd;
  logic [LEN_W-1:0] stk_q [MAX_DEPTH];

  assign ch       = in_if.char_in;
  assign in_fire  = in_if.valid && in_ready;
  assign is_zero  = (ch == '0);
  assign is_sep   = (ch == SEP_CH);
  assign is_dot   = (ch == DOT_CH);
  assign top_q    = stk_q[0];
  assign can_pop  = (cnt_r > CNT_W'(1));
  assign pop_top  = can_pop ? stk_q[1] : stk_q[0];
  assign idx_inc  = idx_r + LEN_W'(1);
  assign too_long = (idx_r >= LEN_W'(MAX_LEN));
  assign too_deep = (cnt_r >= CNT_W'(MAX_DEPTH));

  // next state
  always_comb begin
    phase_nxt = phase_r;
    cls_nxt   = cls_r;
    err_nxt   = err_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    if (in_fire) begin
      case (phase_r)
        PH_DRAIN: begin
          if (is_zero) begin
            phase_nxt = PH_AWAIT;
            cls_nxt   = CLS_SEP;
            err_nxt   = ST_OK;
            idx_nxt   = '0;
            cnt_nxt   = '0;
          end
        end
        PH_PATH: begin
          if (is_zero) begin
            phase_nxt = PH_AWAIT;
            cls_nxt   = CLS_SEP;
            err_nxt   = ST_OK;
            idx_nxt   = '0;
            cnt_nxt   = '0;
          end else if (is_sep) begin
            case (cls_r)
              CLS_SEP: ;
              CLS_DOT: begin
                cls_nxt = CLS_SEP;
                idx_nxt = top_q;
              end
              CLS_DOTDOT: begin
                cls_nxt = CLS_SEP;
                idx_nxt = pop_top;
                if (can_pop) begin
                  cnt_nxt = cnt_r - CNT_W'(1);
                end
              end
              default: begin
                if (too_long || too_deep) begin
                  phase_nxt = PH_DRAIN;
                  err_nxt   = too_long ? ST_TOO_LONG : ST_TOO_DEEP;
                  idx_nxt   = '0;
                  cnt_nxt   = '0;
                end else begin
                  cls_nxt = CLS_SEP;
                  idx_nxt = idx_inc;
                  cnt_nxt = cnt_r + CNT_W'(1);
                end
              end
            endcase
          end else begin
            if (is_dot && cls_r == CLS_SEP) begin
              cls_nxt = CLS_DOT;
            end else if (is_dot && cls_r == CLS_DOT) begin
              cls_nxt = CLS_DOTDOT;
            end else begin
              cls_nxt = CLS_SEG;
            end
            if (too_long) begin
              phase_nxt = PH_DRAIN;
              err_nxt   = ST_TOO_LONG;
              idx_nxt   = '0;
              cnt_nxt   = '0;
            end else begin
              idx_nxt = idx_inc;
            end
          end
        end
        default: begin
          cls_nxt = CLS_SEP;
          err_nxt = ST_OK;
          idx_nxt = '0;
          cnt_nxt = '0;
          if (!is_zero) begin
            if (!is_sep) begin
              phase_nxt = PH_DRAIN;
              err_nxt   = ST_NOT_ABS;
            end else begin
              phase_nxt = PH_PATH;
              idx_nxt   = LEN_W'(1);
              cnt_nxt   = CNT_W'(1);
            end
          end
        end
      endcase
    end
  end

  // result and stack command
  always_comb begin
    res_d     = '0;
    cmd       = '0;
    case (phase_r)
      PH_DRAIN: begin
        if (is_zero) begin
          res_d.done_res = 1'b1;
          res_d.status   = err_r;
        end
      end
      PH_PATH: begin
        if (is_zero) begin
          res_d.done_res = 1'b1;
          case (cls_r)
            CLS_SEP:    res_d.path_length = idx_r;
            CLS_DOT:    res_d.path_length = top_q;
            CLS_DOTDOT: res_d.path_length = pop_top;
            default: begin
              if (split_r) begin
                res_d.file_start  = top_q;
                res_d.file_length = idx_r - top_q;
                res_d.path_length = top_q;
              end else if (too_long) begin
                res_d.status = ST_TOO_LONG;
              end else begin
                res_d.write_valid = 1'b1;
                res_d.write_pos   = idx_r[POS_W-1:0];
                res_d.write_char  = SEP_CH;
                res_d.path_length = idx_inc;
              end
            end
          endcase
        end else if (is_sep) begin
          case (cls_r)
            CLS_SEP: res_d.path_length = idx_r;
            CLS_DOT: res_d.path_length = top_q;
            CLS_DOTDOT: begin
              res_d.path_length = pop_top;
              cmd.pop           = can_pop;
            end
            default: begin
              if (!too_long && !too_deep) begin
                res_d.write_valid = 1'b1;
                res_d.write_pos   = idx_r[POS_W-1:0];
                res_d.write_char  = SEP_CH;
                res_d.path_length = idx_inc;
                cmd.push          = 1'b1;
                cmd.push_val      = idx_inc;
              end
            end
          endcase
        end else if (!too_long) begin
          res_d.write_valid = 1'b1;
          res_d.write_pos   = idx_r[POS_W-1:0];
          res_d.write_char  = ch;
          res_d.path_length = idx_inc;
        end
      end
      default: begin
        if (is_zero) begin
          res_d.done_res = 1'b1;
          res_d.status   = ST_EMPTY;
        end else if (is_sep) begin
          res_d.write_valid = 1'b1;
          res_d.write_pos   = '0;
          res_d.write_char  = SEP_CH;
          res_d.path_length = LEN_W'(1);
          cmd.push          = 1'b1;
          cmd.push_val      = LEN_W'(1);
        end
      end
    endcase
    if (!in_fire) begin
      cmd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_AWAIT;
      cls_r   <= CLS_SEP;
      err_r   <= ST_OK;
      idx_r   <= '0;
      cnt_r   <= '0;
      split_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cls_r   <= cls_nxt;
      err_r   <= err_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_if.valid) begin
        split_r <= cfg_if.split_file;
      end
    end
  end

  assign cfg_if.ready = 1'b1;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_stk
    logic [LEN_W-1:0] up_val, down_val;
    if (i == 0) begin : g_top
      assign up_val = cmd.push_val;
    end else begin : g_mid
      assign up_val = stk_q[i-1];
    end
    if (i == MAX_DEPTH - 1) begin : g_bot
      assign down_val = '0;
    end else begin : g_low
      assign down_val = stk_q[i+1];
    end
    pdsc_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .up_val   (up_val),
      .down_val (down_val),
      .q        (stk_q[i])
    );
  end

  pdsc_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_fire),
    .in_ready  (in_ready),
    .in_res    (res_d),
    .out_valid (res_v),
    .out_ready (out_if.ready),
    .out_res   (res_q)
  );

  assign in_if.ready        = in_ready;
  assign out_if.valid       = res_v;
  assign out_if.write_valid = res_q.write_valid;
  assign out_if.write_pos   = res_q.write_pos;
  assign out_if.write_char  = res_q.write_char;
  assign out_if.path_length = res_q.path_length;
  assign out_if.done_res    = res_q.done_res;
  assign out_if.status      = res_q.status;
  assign out_if.file_start  = res_q.file_start;
  assign out_if.file_length = res_q.file_length;

  `PDSC_ASSERT_NOW(a_path_has_root, phase_r == PH_PATH, cnt_r != '0 && idx_r != '0)
  `PDSC_ASSERT_NOW(a_depth_bound, 1'b1, cnt_r <= CNT_W'(MAX_DEPTH))
  `PDSC_ASSERT_NOW(a_drain_cleared, phase_r == PH_DRAIN, cnt_r == '0 && idx_r == '0)
  `PDSC_ASSERT_NEXT(a_root_opens, in_fire && phase_r == PH_AWAIT && is_sep,
                    phase_r == PH_PATH && idx_r == LEN_W'(1) && stk_q[0] == LEN_W'(1))

endmodule
